// ===== src/pcp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcp_pkg
// Shared constants for the point-in-convex-polygon block.
// ----------------------------------------------------------------------------
package pcp_pkg;

  localparam int MAX_VERTS_DEF  = 16;
  localparam int COORD_BITS_DEF = 16;

  localparam int SLOT_W   = 4;
  localparam int VCOUNT_W = 5;
  localparam int TOL_W    = 32;
  localparam int APB_DW   = 32;
  localparam int APB_AW   = 3;

  localparam int MIN_VERTS = 3;

  localparam logic [TOL_W-1:0] TOL_RESET = TOL_W'(1);

  // register index, taken from paddr[2]
  localparam logic REG_VCOUNT = 1'b0;
  localparam logic REG_TOL    = 1'b1;

  localparam logic FUNC_WRITE = 1'b0;
  localparam logic FUNC_QUERY = 1'b1;

endpackage

// ===== src/pcp_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcp_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module pcp_ram #(
  parameter int W = 32,
  parameter int D = 16
) (
  input  logic                 clk_i,
  input  logic                 we_i,
  input  logic [$clog2(D)-1:0] waddr_i,
  input  logic [W-1:0]         wdata_i,
  input  logic                 re_i,
  input  logic [$clog2(D)-1:0] raddr_i,
  output logic [W-1:0]         rdata_o
);

  logic [W-1:0] mem [D];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

// ===== src/point_in_convex_polygon.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// point_in_convex_polygon
// Convex polygon point test by edge cross products on a shared multiplier.
// ----------------------------------------------------------------------------
//  channel  | dir | handshake                    | contents
//  s_axis   | in  | s_axis_tvalid / s_axis_tready | tuser: func; tdata: slot, x, y
//  m_axis   | out | m_axis_tvalid / m_axis_tready | tuser: too_few; tdata: inside_res
//  apb      | in  | psel, penable, pwrite, pready | 0x0 vertex_count, 0x4 tolerance
//
// A vertex write is taken while idle. A query with fewer than three vertices
// goes from idle to ST_DONE; otherwise it loads vertex 0 and scans the edges
// (all n, fewer on an early outside exit) through ST_DIFF, ST_MUL1, ST_MUL2,
// ST_SUB and ST_CMP: the single multiplier is used twice per edge, then
// subtract and compare. s_axis_tready is high only while idle; a result
// waiting in the output register holds the next result back. Reset clears
// control, configuration and output registers; the vertex store is not cleared.
// ----------------------------------------------------------------------------
module point_in_convex_polygon #(
  parameter int MAX_VERTS  = pcp_pkg::MAX_VERTS_DEF,
  parameter int COORD_BITS = pcp_pkg::COORD_BITS_DEF,
  localparam int TDATA_W   = ((pcp_pkg::SLOT_W + 2 * COORD_BITS) + 7) / 8 * 8
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // stream in
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  input  logic [TDATA_W-1:0]          s_axis_tdata,  // slot, coord_x, coord_y
  input  logic [0:0]                  s_axis_tuser,  // func
  // stream out
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  output logic [7:0]                  m_axis_tdata,  // inside_res
  output logic [0:0]                  m_axis_tuser,  // too_few
  // configuration
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [pcp_pkg::APB_AW-1:0]  paddr,
  input  logic [pcp_pkg::APB_DW-1:0]  pwdata,
  output logic [pcp_pkg::APB_DW-1:0]  prdata,
  output logic                        pready
);

  import pcp_pkg::*;

  localparam int CB = COORD_BITS;
  localparam int AW = $clog2(MAX_VERTS);
  localparam int NW = $clog2(MAX_VERTS + 1);
  localparam int DW = CB + 1;          // coordinate difference
  localparam int PW = 2 * DW;          // one product
  localparam int XW = PW + 1;          // cross product
  localparam int CW = (XW > TOL_W) ? XW : TOL_W;

  typedef enum logic [2:0] {
    ST_IDLE, ST_LOAD0, ST_DIFF, ST_MUL1, ST_MUL2, ST_SUB, ST_CMP, ST_DONE
  } state_e;

  typedef enum logic [1:0] {
    SGN_NONE = 2'd0, SGN_POS = 2'd1, SGN_NEG = 2'd2
  } sign_e;

  state_e state_q;
  sign_e  first_q;
  logic   [AW-1:0] idx_q;

  // configuration
  logic [VCOUNT_W-1:0] vcount_q;
  logic [TOL_W-1:0]    tol_q;
  logic                cfg_we;

  assign pready = 1'b1;
  assign cfg_we = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vcount_q <= '0;
      tol_q    <= TOL_RESET;
    end else if (cfg_we) begin
      case (paddr[2])
        REG_VCOUNT: vcount_q <= pwdata[VCOUNT_W-1:0];
        REG_TOL:    tol_q    <= pwdata[TOL_W-1:0];
        default:    ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_VCOUNT: prdata = APB_DW'(vcount_q);
      REG_TOL:    prdata = APB_DW'(tol_q);
      default:    prdata = '0;
    endcase
  end

  // input fields
  logic                 in_func;
  logic [SLOT_W-1:0]    in_slot;
  logic [CB-1:0]        in_x, in_y;
  logic                 in_acc;

  assign in_func = s_axis_tuser[0];
  assign in_slot = s_axis_tdata[SLOT_W-1:0];
  assign in_x    = s_axis_tdata[SLOT_W +: CB];
  assign in_y    = s_axis_tdata[SLOT_W + CB +: CB];

  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_acc        = s_axis_tvalid & s_axis_tready;

  // effective vertex count, clamped to the store depth
  logic [31:0]   cnt_raw, cnt_eff;
  logic [NW-1:0] n_eff;
  logic          too_few;

  assign cnt_raw = 32'(vcount_q);
  assign cnt_eff = (cnt_raw > 32'(MAX_VERTS)) ? 32'(MAX_VERTS) : cnt_raw;
  assign n_eff   = NW'(cnt_eff);
  assign too_few = cnt_eff < 32'(MIN_VERTS);

  // vertex store
  logic            ram_we, ram_re;
  logic [AW-1:0]   ram_waddr, ram_raddr;
  logic [2*CB-1:0] ram_rdata;
  logic [31:0]     slot_ext;

  assign slot_ext  = 32'(in_slot);
  assign ram_we    = in_acc && (in_func == FUNC_WRITE) && (slot_ext < 32'(MAX_VERTS));
  assign ram_waddr = slot_ext[AW-1:0];

  pcp_ram #(
    .W (2 * CB),
    .D (MAX_VERTS)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i ({in_y, in_x}),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // edge bookkeeping
  logic          last_edge;
  logic [NW:0]   nxt2;
  logic          more_reads;

  assign last_edge  = (NW'(idx_q) + NW'(1)) == n_eff;
  assign nxt2       = (NW + 1)'(idx_q) + (NW + 1)'(2);
  assign more_reads = nxt2 < (NW + 1)'(n_eff);

  always_comb begin
    ram_re    = 1'b0;
    ram_raddr = '0;
    case (state_q)
      ST_IDLE: begin
        ram_re    = in_acc && (in_func == FUNC_QUERY) && !too_few;
        ram_raddr = '0;
      end
      ST_LOAD0: begin
        ram_re    = 1'b1;
        ram_raddr = AW'(1);
      end
      ST_CMP: begin
        ram_re    = more_reads;
        ram_raddr = nxt2[AW-1:0];
      end
      default: ;
    endcase
  end

  // datapath
  logic signed [CB-1:0] px_q, py_q, ax_q, ay_q, v0x_q, v0y_q;
  logic signed [CB-1:0] rx, ry, bx, by;
  logic signed [DW-1:0] abx_q, aby_q, apx_q, apy_q;
  logic signed [DW-1:0] mul_a, mul_b;
  logic signed [PW-1:0] prod, p1_q, p2_q;
  logic signed [XW-1:0] cross_q;
  logic        [XW-1:0] mag;
  logic                 skip, pos;
  sign_e                cur;

  assign rx = ram_rdata[CB-1:0];
  assign ry = ram_rdata[2*CB-1:CB];
  assign bx = last_edge ? v0x_q : rx;
  assign by = last_edge ? v0y_q : ry;

  // the shared multiplier
  assign mul_a = (state_q == ST_MUL1) ? abx_q : aby_q;
  assign mul_b = (state_q == ST_MUL1) ? apy_q : apx_q;
  assign prod  = mul_a * mul_b;

  assign mag  = cross_q[XW-1] ? XW'(-cross_q) : XW'(cross_q);
  assign skip = CW'(mag) < CW'(tol_q);
  assign pos  = !cross_q[XW-1] && (cross_q != '0);
  assign cur  = pos ? SGN_POS : SGN_NEG;

  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        px_q <= in_x;
        py_q <= in_y;
      end
      ST_LOAD0: begin
        ax_q  <= rx;
        ay_q  <= ry;
        v0x_q <= rx;
        v0y_q <= ry;
      end
      ST_DIFF: begin
        abx_q <= DW'(bx) - DW'(ax_q);
        aby_q <= DW'(by) - DW'(ay_q);
        apx_q <= DW'(px_q) - DW'(ax_q);
        apy_q <= DW'(py_q) - DW'(ay_q);
        ax_q  <= bx;
        ay_q  <= by;
      end
      ST_MUL1: p1_q <= prod;
      ST_MUL2: p2_q <= prod;
      ST_SUB:  cross_q <= XW'(p1_q) - XW'(p2_q);
      default: ;
    endcase
  end

  // sequencer and output register
  logic res_inside_q, res_few_q;
  logic out_valid_q, out_inside_q, out_few_q;
  logic out_free;

  assign out_free = !out_valid_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      first_q      <= SGN_NONE;
      idx_q        <= '0;
      res_inside_q <= 1'b0;
      res_few_q    <= 1'b0;
      out_valid_q  <= 1'b0;
      out_inside_q <= 1'b0;
      out_few_q    <= 1'b0;
    end else begin
      // ST_DONE handles the output register itself
      if (m_axis_tready && (state_q != ST_DONE)) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_acc && (in_func == FUNC_QUERY)) begin
            idx_q   <= '0;
            first_q <= SGN_NONE;
            if (too_few) begin
              res_inside_q <= 1'b0;
              res_few_q    <= 1'b1;
              state_q      <= ST_DONE;
            end else begin
              state_q <= ST_LOAD0;
            end
          end
        end
        ST_LOAD0: state_q <= ST_DIFF;
        ST_DIFF:  state_q <= ST_MUL1;
        ST_MUL1:  state_q <= ST_MUL2;
        ST_MUL2:  state_q <= ST_SUB;
        ST_SUB:   state_q <= ST_CMP;
        ST_CMP: begin
          res_few_q <= 1'b0;
          if (!skip && (first_q != SGN_NONE) && (cur != first_q)) begin
            res_inside_q <= 1'b0;
            state_q      <= ST_DONE;
          end else begin
            if (!skip && (first_q == SGN_NONE)) begin
              first_q <= cur;
            end
            if (last_edge) begin
              res_inside_q <= 1'b1;
              state_q      <= ST_DONE;
            end else begin
              idx_q   <= idx_q + AW'(1);
              state_q <= ST_DIFF;
            end
          end
        end
        ST_DONE: begin
          if (out_free) begin
            out_valid_q  <= 1'b1;
            out_inside_q <= res_inside_q;
            out_few_q    <= res_few_q;
            first_q      <= SGN_NONE;
            idx_q        <= '0;
            state_q      <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {7'b0, out_inside_q};
  assign m_axis_tuser  = out_few_q;

endmodule

// ===== verif/polygon_test_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// polygon_test_checker
// Watches the request, result and register channels of the polygon block,
// keeps its own vertex store and register copies, predicts the verdict of
// every point query and compares it with the result that comes back.
// ----------------------------------------------------------------------------
module polygon_test_checker #(
  parameter int TDATA_W = 40
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         s_axis_tvalid,
  input  logic                         s_axis_tready,
  input  logic [TDATA_W-1:0]           s_axis_tdata,  // slot, coord_x, coord_y
  input  logic [0:0]                   s_axis_tuser,  // func
  input  logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  input  logic [7:0]                   m_axis_tdata,  // inside_res
  input  logic [0:0]                   m_axis_tuser,  // too_few
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [pcp_pkg::APB_AW-1:0]   paddr,
  input  logic [pcp_pkg::APB_DW-1:0]   pwdata,
  input  logic [pcp_pkg::APB_DW-1:0]   prdata,
  input  logic                         pready,
  output int                           mismatch_cnt_o,
  output int                           pending_o,
  output int                           inside_cnt_o,
  output int                           outside_cnt_o,
  output int                           too_few_cnt_o
);

  import pcp_pkg::*;

  localparam int X_LSB = SLOT_W;
  localparam int Y_LSB = SLOT_W + COORD_BITS_DEF;

  typedef enum logic [1:0] {SIGN_NONE, SIGN_POS, SIGN_NEG} edge_sign_e;
  typedef struct packed {
    logic inside_res;
    logic too_few;
  } verdict_t;

  logic signed [COORD_BITS_DEF-1:0] vert_x [MAX_VERTS_DEF];
  logic signed [COORD_BITS_DEF-1:0] vert_y [MAX_VERTS_DEF];
  logic [VCOUNT_W-1:0]              vcount;
  logic [TOL_W-1:0]                 tol;
  verdict_t                         verdict_q [$];
  int                               fail_cnt;
  int                               result_cnt;
  int                               inside_cnt;
  int                               outside_cnt;
  int                               too_few_cnt;

  function automatic verdict_t classify_point(logic signed [COORD_BITS_DEF-1:0] px,
                                              logic signed [COORD_BITS_DEF-1:0] py);
    verdict_t        v;
    int              n;
    int              nxt;
    longint          abx, aby, apx, apy, xprod;
    longint unsigned mag;
    edge_sign_e      first, cur;
    v = '{inside_res: 1'b1, too_few: 1'b0};
    first = SIGN_NONE;
    n = (vcount > MAX_VERTS_DEF) ? MAX_VERTS_DEF : int'(vcount);
    if (n < MIN_VERTS) begin
      v = '{inside_res: 1'b0, too_few: 1'b1};
    end else begin
      // scan stops at the first edge that disagrees with the first sign
      for (int e = 0; e < n && v.inside_res; e++) begin
        nxt = (e + 1 == n) ? 0 : e + 1;
        abx = longint'(vert_x[nxt]) - longint'(vert_x[e]);
        aby = longint'(vert_y[nxt]) - longint'(vert_y[e]);
        apx = longint'(px) - longint'(vert_x[e]);
        apy = longint'(py) - longint'(vert_y[e]);
        xprod = abx * apy - aby * apx;
        mag = (xprod < 0) ? -xprod : xprod;
        // below tolerance: on the edge, skipped; exact zero otherwise negative
        if (mag >= 64'(tol)) begin
          cur = (xprod > 0) ? SIGN_POS : SIGN_NEG;
          if (first == SIGN_NONE) begin
            first = cur;
          end else if (cur != first) begin
            v.inside_res = 1'b0;
          end
        end
      end
    end
    return v;
  endfunction

  function automatic void note_failure(string msg);
    fail_cnt++;
    if (fail_cnt <= 10) $display("[%0t] MISMATCH: %s", $time, msg);
  endfunction

  always @(posedge clk_i) begin : watch
    verdict_t            got, exp_v;
    logic [APB_DW-1:0]   reg_val;
    logic [SLOT_W-1:0]   slot;
    if (!rst_ni) begin
      vcount = '0;
      tol    = TOL_RESET;
      verdict_q.delete();
    end else begin
      // result side first: a query accepted at this edge cannot answer yet
      if (m_axis_tvalid && m_axis_tready) begin
        got = '{inside_res: m_axis_tdata[0], too_few: m_axis_tuser[0]};
        if (verdict_q.size() == 0) begin
          note_failure($sformatf("result with no query pending: inside=%0b too_few=%0b",
                                 got.inside_res, got.too_few));
        end else begin
          exp_v = verdict_q.pop_front();
          result_cnt++;
          if (exp_v.too_few) too_few_cnt++;
          else if (exp_v.inside_res) inside_cnt++;
          else outside_cnt++;
          if (got !== exp_v) begin
            note_failure($sformatf(
              "result %0d: expected inside=%0b too_few=%0b, got inside=%0b too_few=%0b",
              result_cnt, exp_v.inside_res, exp_v.too_few, got.inside_res, got.too_few));
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        if (s_axis_tuser[0] == FUNC_WRITE) begin
          slot = s_axis_tdata[SLOT_W-1:0];
          vert_x[slot] = s_axis_tdata[X_LSB +: COORD_BITS_DEF];
          vert_y[slot] = s_axis_tdata[Y_LSB +: COORD_BITS_DEF];
        end else begin
          verdict_q.insert(verdict_q.size(),
                           classify_point(s_axis_tdata[X_LSB +: COORD_BITS_DEF],
                                          s_axis_tdata[Y_LSB +: COORD_BITS_DEF]));
        end
      end
      if (psel && penable && pready) begin
        if (pwrite) begin
          if (paddr[2] == REG_VCOUNT) vcount = pwdata[VCOUNT_W-1:0];
          else tol = pwdata[TOL_W-1:0];
        end else begin
          reg_val = (paddr[2] == REG_VCOUNT) ? APB_DW'(vcount) : APB_DW'(tol);
          if (prdata !== reg_val) begin
            note_failure($sformatf("register read at 0x%0h: expected 0x%08h, got 0x%08h",
                                   paddr, reg_val, prdata));
          end
        end
      end
    end
    mismatch_cnt_o <= fail_cnt;
    pending_o      <= verdict_q.size();
    inside_cnt_o   <= inside_cnt;
    outside_cnt_o  <= outside_cnt;
    too_few_cnt_o  <= too_few_cnt;
  end

endmodule

// ===== verif/tb_point_in_convex_polygon.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_point_in_convex_polygon
// Loads polygons of many shapes and sizes, sweeps vertex count and edge
// tolerance through their extremes and fires point queries with random
// stalls on both streams; verdicts are checked by polygon_test_checker.
// ----------------------------------------------------------------------------
module tb_point_in_convex_polygon;
  import pcp_pkg::*;

  localparam int TDATA_W       = ((SLOT_W + 2 * COORD_BITS_DEF) + 7) / 8 * 8;
  localparam int ITEM_TARGET   = 950;
  localparam int IDLE_PCT      = 14;
  localparam int SETTLE_CYCLES = 8;
  localparam int CALM_PHASE    = 4;
  localparam int TRIG_SCALE    = 10000;
  // cos(k * 22.5 deg) scaled; sin(k) is entry (k + 12) mod 16
  localparam int COS_TAB [16] = '{10000, 9239, 7071, 3827, 0, -3827, -7071, -9239,
                                  -10000, -9239, -7071, -3827, 0, 3827, 7071, 9239};

  typedef enum int {SHAPE_CONVEX, SHAPE_SCATTER, SHAPE_LINE} shape_e;

  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [TDATA_W-1:0]  s_axis_tdata  = '0;  // slot, coord_x, coord_y
  logic [0:0]          s_axis_tuser  = '0;  // func
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [7:0]          m_axis_tdata;        // inside_res
  logic [0:0]          m_axis_tuser;        // too_few
  logic                psel          = 1'b0;
  logic                penable       = 1'b0;
  logic                pwrite        = 1'b0;
  logic [APB_AW-1:0]   paddr         = '0;
  logic [APB_DW-1:0]   pwdata        = '0;
  logic [APB_DW-1:0]   prdata;
  logic                pready;

  int  mismatches, pending, n_inside, n_outside, n_too_few;
  bit  calm;
  int  poly_x [16];
  int  poly_y [16];
  int  poly_n;
  int  ctr_x, ctr_y, rad_x, rad_y;
  int  writes_sent, queries_sent, settings;

  point_in_convex_polygon dut (.*);

  polygon_test_checker #(.TDATA_W(TDATA_W)) u_check (
    .*,
    .mismatch_cnt_o (mismatches),
    .pending_o      (pending),
    .inside_cnt_o   (n_inside),
    .outside_cnt_o  (n_outside),
    .too_few_cnt_o  (n_too_few)
  );

  always #4 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (!rst_ni) m_axis_tready <= 1'b0;
    else m_axis_tready <= calm || ($urandom_range(99) >= IDLE_PCT);
  end

  initial begin
    #4_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  function automatic logic signed [15:0] sat16(int v);
    if (v > 32767) return 16'h7FFF;
    if (v < -32768) return 16'h8000;
    return 16'(v);
  endfunction

  function automatic int any_coord();
    return int'($urandom_range(65535)) - 32768;
  endfunction

  function automatic int pick_radius();
    case ($urandom_range(3))
      0: return int'($urandom_range(1, 64));
      1: return int'($urandom_range(65, 4000));
      2: return int'($urandom_range(4001, 32767));
      default: return 32767;
    endcase
  endfunction

  task automatic send_req(logic func, logic [SLOT_W-1:0] slot, int x, int y);
    logic rdy;
    while (!calm && $urandom_range(99) < IDLE_PCT) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= func;
    s_axis_tdata  <= TDATA_W'({sat16(y), sat16(x), slot});
    do begin
      @(negedge clk_i);
      rdy = s_axis_tready;
      @(posedge clk_i);
    end while (!rdy);
    if (func == FUNC_WRITE) writes_sent++;
    else queries_sent++;
  endtask

  task automatic write_vertex(logic [SLOT_W-1:0] slot, int x, int y);
    poly_x[slot] = int'(sat16(x));
    poly_y[slot] = int'(sat16(y));
    send_req(FUNC_WRITE, slot, x, y);
  endtask

  // drop valid, let every query answer, then give the block time to settle
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    do @(negedge clk_i); while (pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic reg_access(bit wr, logic idx, logic [APB_DW-1:0] val);
    logic rdy;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    do begin
      @(negedge clk_i);
      rdy = pready;
      @(posedge clk_i);
    end while (!rdy);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  // vertices go to slots 0..n-1 in order; convex shapes lie around the ellipse at ctr/rad
  task automatic load_polygon(int n, shape_e shape);
    bit [15:0] dirs;
    int        left, j, k, s, start;
    bit        cw;
    dirs  = '1;
    left  = 16;
    while (left > n) begin
      j = $urandom_range(15);
      if (dirs[j]) begin
        dirs[j] = 1'b0;
        left--;
      end
    end
    start = $urandom_range(15);
    cw    = 1'($urandom_range(1));
    s     = 0;
    for (int step = 0; step < 16; step++) begin
      k = cw ? ((start - step) & 15) : ((start + step) & 15);
      if (dirs[k]) begin
        case (shape)
          SHAPE_CONVEX:
            write_vertex(SLOT_W'(s), ctr_x + rad_x * COS_TAB[k] / TRIG_SCALE,
                         ctr_y + rad_y * COS_TAB[(k + 12) % 16] / TRIG_SCALE);
          SHAPE_SCATTER:
            write_vertex(SLOT_W'(s), any_coord(), any_coord());
          default:
            write_vertex(SLOT_W'(s), ctr_x + rad_x * (step - 8) / 8,
                         ctr_y + rad_y * (step - 8) / 8);
        endcase
        s++;
      end
    end
    poly_n = n;
  endtask

  task automatic query_point();
    int x, y, j, nx, span_x, span_y;
    j  = $urandom_range(poly_n - 1);
    nx = (j + 1) % poly_n;
    case ($urandom_range(9))
      0, 1: begin
        x = any_coord();
        y = any_coord();
      end
      2: begin
        x = poly_x[j];
        y = poly_y[j];
      end
      3: begin
        x = (poly_x[j] + poly_x[nx]) / 2;
        y = (poly_y[j] + poly_y[nx]) / 2;
      end
      4: begin
        x = $urandom_range(1) ? 32767 : -32768;
        y = $urandom_range(1) ? 32767 : -32768;
      end
      default: begin
        span_x = rad_x + rad_x / 4 + 1;
        span_y = rad_y + rad_y / 4 + 1;
        x = ctr_x + int'($urandom_range(2 * span_x)) - span_x;
        y = ctr_y + int'($urandom_range(2 * span_y)) - span_y;
      end
    endcase
    send_req(FUNC_QUERY, SLOT_W'($urandom_range(15)), x, y);
  endtask

  initial begin
    int          vc, n, phase;
    logic [31:0] tol_val;
    shape_e      shape;
    poly_n = 1;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset values of both registers, then a query with no vertices in use
    reg_access(1'b0, REG_VCOUNT, '0);
    reg_access(1'b0, REG_TOL, '0);
    send_req(FUNC_QUERY, 4'hF, 0, 0);

    // full-scale 16-gon fills every slot
    ctr_x = 0;
    ctr_y = 0;
    rad_x = 32767;
    rad_y = 32767;
    load_polygon(16, SHAPE_CONVEX);

    wait_idle();
    reg_access(1'b1, REG_VCOUNT, 32'd2);
    send_req(FUNC_QUERY, 4'h0, 0, 0);

    wait_idle();
    reg_access(1'b1, REG_VCOUNT, 32'd3);
    poly_n = 3;
    send_req(FUNC_QUERY, 4'h5, 100, -100);

    // zero tolerance: points on a vertex or an edge see exact zero products
    wait_idle();
    reg_access(1'b1, REG_VCOUNT, 32'd16);
    reg_access(1'b1, REG_TOL, 32'd0);
    poly_n = 16;
    send_req(FUNC_QUERY, 4'hA, poly_x[5], poly_y[5]);
    send_req(FUNC_QUERY, 4'h3, (poly_x[2] + poly_x[3]) / 2, (poly_y[2] + poly_y[3]) / 2);
    send_req(FUNC_QUERY, 4'h0, -32768, -32768);
    send_req(FUNC_QUERY, 4'hF, 32767, 32767);

    wait_idle();
    reg_access(1'b1, REG_TOL, 32'hFFFF_FFFF);
    reg_access(1'b0, REG_TOL, '0);
    send_req(FUNC_QUERY, 4'h9, 32767, -32768);

    // count above the slot range is clamped to all slots
    wait_idle();
    reg_access(1'b1, REG_VCOUNT, 32'd31);
    reg_access(1'b1, REG_TOL, 32'd1);
    reg_access(1'b0, REG_VCOUNT, '0);
    write_vertex(4'hF, -32768, 32767);
    send_req(FUNC_QUERY, 4'h6, 0, 0);
    send_req(FUNC_QUERY, 4'h1, -32768, 32767);

    phase = 0;
    while (writes_sent + queries_sent < ITEM_TARGET) begin
      wait_idle();
      calm <= (phase == CALM_PHASE);
      case ($urandom_range(9))
        0: vc = $urandom_range(2);
        1: vc = $urandom_range(17, 31);
        2, 3: vc = 16;
        4: vc = 3;
        default: vc = $urandom_range(4, 15);
      endcase
      case ($urandom_range(7))
        0: tol_val = 32'd0;
        1: tol_val = 32'd1;
        2: tol_val = $urandom_range(2, 1000);
        3: tol_val = $urandom_range(1001, 1 << 24);
        4: tol_val = $urandom();
        5: tol_val = 32'hFFFF_FFFF;
        default: tol_val = 32'd1;
      endcase
      // upper bits of the count register are don't-care on write
      reg_access(1'b1, REG_VCOUNT,
                 32'(vc) | (($urandom_range(3) == 0) ? ($urandom() & ~32'h1F) : 32'd0));
      reg_access(1'b1, REG_TOL, tol_val);
      if ($urandom_range(3) == 0) begin
        reg_access(1'b0, REG_VCOUNT, '0);
        reg_access(1'b0, REG_TOL, '0);
      end
      settings++;

      n = (vc > 16) ? 16 : ((vc < 3) ? 3 : vc);
      case ($urandom_range(19))
        0, 1, 2: shape = SHAPE_SCATTER;
        3, 4: shape = SHAPE_LINE;
        default: shape = SHAPE_CONVEX;
      endcase
      rad_x = pick_radius();
      rad_y = ($urandom_range(1) == 0) ? rad_x : pick_radius();
      ctr_x = int'($urandom_range(65535 - 2 * rad_x)) - 32768 + rad_x;
      ctr_y = int'($urandom_range(65535 - 2 * rad_y)) - 32768 + rad_y;
      load_polygon(n, shape);

      // mostly queries; a few stray vertex writes bend the polygon mid-run
      repeat ($urandom_range(40, 90)) begin
        if ($urandom_range(99) < 8) begin
          write_vertex(SLOT_W'($urandom_range(15)), any_coord(), any_coord());
        end else begin
          query_point();
        end
      end
      phase++;
    end

    wait_idle();
    $display("Covered %0d vertex writes and %0d point queries over %0d register settings.",
             writes_sent, queries_sent, settings + 6);
    $display("Verdicts seen: %0d inside, %0d outside, %0d too few vertices; %0d mismatches.",
             n_inside, n_outside, n_too_few, mismatches);
    if (mismatches == 0 && pending == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ===== files.f =====
src/pcp_pkg.sv
src/pcp_ram.sv
src/point_in_convex_polygon.sv
verif/polygon_test_checker.sv
verif/tb_point_in_convex_polygon.sv
